// File: hdl/three_term_recurrence_checksum_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the three-term recurrence checksum block.
// ----------------------------------------------------------------------------
`ifndef THREE_TERM_RECURRENCE_CHECKSUM_MACROS_SVH
`define THREE_TERM_RECURRENCE_CHECKSUM_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTRC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TTRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/ttrc_pkg.sv
// ----------------------------------------------------------------------------
// ttrc_pkg
// Types, constants and the modulo-65535 reduction shared by the checksum block.
// ----------------------------------------------------------------------------
package ttrc_pkg;

	// Recurrence constants.
	localparam logic [7:0]  ALPHA_MUL    = 8'd17;
	localparam logic [7:0]  BETA_MUL     = 8'd31;
	localparam logic [15:0] FIRST_OFFSET = 16'd7;
	localparam logic [15:0] CK_MOD       = 16'hFFFF;

	// Running state of one message.
	typedef struct packed {
		logic [15:0] older;
		logic [15:0] newer;
		logic [7:0]  pos;
		logic        started;
	} state_t;

	localparam state_t STATE_RESET = '{older: 16'd1, newer: 16'd0, pos: 8'd0, started: 1'b0};

	// Outcome of one byte step: the next state and an optional checksum.
	typedef struct packed {
		state_t      nxt;
		logic        emit;
		logic [15:0] checksum;
	} step_t;

	// Reduces a 25-bit value modulo 65535 by folding the upper half onto the lower.
	function automatic logic [15:0] mod65535(input logic [24:0] x);
		logic [16:0] s1;
		logic [15:0] s2;
		s1 = {8'd0, x[24:16]} + {1'b0, x[15:0]};
		// When s1 overflows 16 bits its low half is small, so this sum cannot overflow.
		s2 = s1[15:0] + {15'd0, s1[16]};
		return (s2 == CK_MOD) ? 16'd0 : s2;
	endfunction

endpackage

// File: hdl/ttrc_in_if.sv
// ----------------------------------------------------------------------------
// ttrc_in_if
// Message byte channel: one transaction carries one byte and its end markers.
// ----------------------------------------------------------------------------
interface ttrc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       is_last;
	logic       no_data;

	modport source(output valid, output data_byte, output is_last, output no_data,
		input ready);
	modport sink(input valid, input data_byte, input is_last, input no_data,
		output ready);
endinterface

// File: hdl/ttrc_out_if.sv
// ----------------------------------------------------------------------------
// ttrc_out_if
// Checksum channel: one transaction carries the checksum of one message.
// ----------------------------------------------------------------------------
interface ttrc_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] checksum;

	modport source(output valid, output checksum, input ready);
	modport sink(input valid, input checksum, output ready);
endinterface

// File: hdl/ttrc_step.sv
// ----------------------------------------------------------------------------
// ttrc_step
// Combinational recurrence step: next state and checksum for one byte.
// ----------------------------------------------------------------------------
module ttrc_step (
	input  ttrc_pkg::state_t st,
	input  logic [7:0]       data_byte,
	input  logic             is_last,
	input  logic             no_data,
	output ttrc_pkg::step_t  step
);

	logic [7:0]  alpha;
	logic [7:0]  beta;
	logic [8:0]  coef;
	logic [24:0] prod_a;
	logic [23:0] prod_b;
	logic        a_ge_b;
	logic [24:0] diff_pos;
	logic [23:0] diff_neg;
	logic [15:0] red_pos;
	logic [15:0] red_neg;
	logic [15:0] term;

	// Position-dependent coefficients, kept modulo 256.
	assign alpha = st.pos * ttrc_pkg::ALPHA_MUL;
	assign beta  = st.pos * ttrc_pkg::BETA_MUL;
	assign coef  = {1'b0, data_byte} + {1'b0, alpha};

	// The two products of the recurrence.
	assign prod_a = 25'(coef) * 25'(st.newer);
	assign prod_b = 24'(beta) * 24'(st.older);

	// A negative difference wraps modulo 2^64, which is one more modulo 65535.
	assign a_ge_b   = prod_a >= {1'b0, prod_b};
	assign diff_pos = prod_a - {1'b0, prod_b};
	assign diff_neg = prod_b - prod_a[23:0];
	assign red_pos  = ttrc_pkg::mod65535(diff_pos);
	assign red_neg  = ttrc_pkg::mod65535({1'b0, diff_neg});

	always_comb begin
		if (a_ge_b) begin
			term = red_pos;
		end else if (red_neg <= 16'd1) begin
			term = 16'd1 - red_neg;
		end else begin
			term = 16'(17'h10000 - {1'b0, red_neg});
		end
	end

	// State update and result selection.
	always_comb begin
		step.nxt      = st;
		step.emit     = 1'b0;
		step.checksum = term;
		if (no_data) begin
			step.emit     = 1'b1;
			step.checksum = st.started ? st.newer : 16'd1;
			step.nxt      = ttrc_pkg::STATE_RESET;
		end else begin
			if (!st.started) begin
				step.checksum    = {8'd0, data_byte} + ttrc_pkg::FIRST_OFFSET;
				step.nxt.older   = 16'd1;
				step.nxt.newer   = step.checksum;
				step.nxt.pos     = 8'd1;
				step.nxt.started = 1'b1;
			end else begin
				step.nxt.older = st.newer;
				step.nxt.newer = term;
				step.nxt.pos   = st.pos + 8'd1;
			end
			if (is_last) begin
				step.emit = 1'b1;
				step.nxt  = ttrc_pkg::STATE_RESET;
			end
		end
	end

endmodule

// File: hdl/three_term_recurrence_checksum.sv
// ----------------------------------------------------------------------------
// three_term_recurrence_checksum
// Byte-serial three-term recurrence checksum with a registered result.
// ----------------------------------------------------------------------------
// The message enters on the msg channel, one byte per transaction. A byte with
// is_last set closes the message; a transaction with no_data set closes it
// without a byte (an empty message gives 1). The checksum leaves on the result
// channel, one transaction per message.
// Each byte is folded into the running terms in the cycle it is accepted, by
// one pass through two narrow multipliers and a modulo-65535 fold. The
// checksum appears on result in the cycle after the closing transaction.
// Throughput is one byte per cycle. While a checksum waits in the output
// register and result.ready is low, msg.ready is held low; it follows
// result.ready combinationally, so a draining output takes a byte in the same
// cycle.
// Reset clears the running terms to their start values and empties the
// output register; msg.ready is high straight after reset.
// ----------------------------------------------------------------------------
module three_term_recurrence_checksum (
	input  logic          clk,
	input  logic          arst_n,
	ttrc_in_if.sink       msg,
	ttrc_out_if.source    result
);

	ttrc_pkg::state_t state_q;
	ttrc_pkg::step_t  step;
	logic             out_valid_q;
	logic [15:0]      checksum_q;
	logic             accept;

	// A new byte is taken whenever the output register is free or draining.
	assign msg.ready = !out_valid_q || result.ready;
	assign accept    = msg.valid && msg.ready;

	ttrc_step u_step (
		.st        (state_q),
		.data_byte (msg.data_byte),
		.is_last   (msg.is_last),
		.no_data   (msg.no_data),
		.step      (step)
	);

	// Running state of the current message.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttrc_pkg::STATE_RESET;
		end else if (accept) begin
			state_q <= step.nxt;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && step.emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (accept && step.emit) begin
			checksum_q <= step.checksum;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.checksum = checksum_q;

endmodule

// File: hdl/ttrc_checker.sv
// ----------------------------------------------------------------------------
// ttrc_checker
// Port-level assertions for the checksum block, bound to its top level.
// ----------------------------------------------------------------------------
`include "three_term_recurrence_checksum_macros.svh"

module ttrc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        is_last,
	input logic        no_data,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] checksum
);

	// A closing transaction always yields a checksum in the next cycle.
	`TTRC_ASSERT_NEXT(a_close_gives_result, clk, arst_n, in_valid && in_ready && (is_last || no_data), out_valid, "closing transaction gave no checksum")

	// The checksum is a residue modulo 65535.
	`TTRC_ASSERT_NOW(a_checksum_range, clk, arst_n, out_valid, checksum != 16'hFFFF, "checksum out of range")

	// An empty output register never stalls the byte stream.
	`TTRC_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !out_valid, in_ready, "input stalled with empty output")

	// A stalled checksum stays offered.
	`TTRC_ASSERT_NEXT(a_hold_valid, clk, arst_n, out_valid && !out_ready, out_valid, "checksum withdrawn while stalled")

endmodule

bind three_term_recurrence_checksum ttrc_checker u_ttrc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (msg.valid),
	.in_ready  (msg.ready),
	.is_last   (msg.is_last),
	.no_data   (msg.no_data),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.checksum  (result.checksum)
);

// File: verif/three_term_recurrence_checksum_tb.sv
// ----------------------------------------------------------------------------
// three_term_recurrence_checksum_tb
// Self-checking bench for the three-term recurrence checksum block.
// ----------------------------------------------------------------------------
// Messages are sent one byte per transaction with random gaps. The bench's
// own copy of the recurrence predicts each checksum when the closing
// transaction is accepted, and every checksum transaction is compared with
// the oldest prediction. The result side stalls at random as well.
// ----------------------------------------------------------------------------
module three_term_recurrence_checksum_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ITEM_TARGET = 900;
	localparam int unsigned DRAIN_LIMIT = 20000;
	localparam longint unsigned RECUR_MOD = 64'd65535;
	localparam logic [7:0] NEW_COEF_STEP = 8'd17;
	localparam logic [7:0] OLD_COEF_STEP = 8'd31;
	localparam logic [15:0] FIRST_BIAS = 16'd7;

	logic clk;
	logic arst_n;

	ttrc_in_if  msg_ch();
	ttrc_out_if sum_ch();

	three_term_recurrence_checksum DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.result (sum_ch)
	);

	// Running terms of the bench's own recurrence.
	logic [15:0] run_older;
	logic [15:0] run_newer;
	logic [7:0]  run_pos;
	logic        run_started;

	logic [15:0] pending_checksums[$];
	int unsigned errors;
	int unsigned items_sent;
	bit          steady;

	// Free-running clock, 12 ns period.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Gap length: mostly none or short, now and then long; none while steady.
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (steady)
			return 0;
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Byte values lean towards the extremes.
	function automatic logic [7:0] pick_byte();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 8'h00;
		if (r < 16)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void clear_terms();
		run_older   = 16'd1;
		run_newer   = 16'd0;
		run_pos     = 8'd0;
		run_started = 1'b0;
	endfunction

	// Folds one accepted transaction into the terms and records any checksum it closes.
	function automatic void fold_transaction(input logic [7:0] b, input logic last,
		input logic none);
		logic [7:0] new_coef;
		logic [7:0] old_coef;
		longint unsigned lead;
		longint unsigned trail;
		longint unsigned diff;
		if (none) begin
			pending_checksums.push_back(run_started ? run_newer : 16'd1);
			clear_terms();
			return;
		end
		if (!run_started) begin
			run_newer   = 16'(b) + FIRST_BIAS;
			run_older   = 16'd1;
			run_started = 1'b1;
			run_pos     = 8'd1;
		end else begin
			new_coef = run_pos * NEW_COEF_STEP;
			old_coef = run_pos * OLD_COEF_STEP;
			lead = (64'(b) + 64'(new_coef)) * 64'(run_newer);
			trail = 64'(old_coef) * 64'(run_older);
			// A negative difference wraps modulo 2^64 before the reduction.
			diff = lead - trail;
			run_older = run_newer;
			run_newer = 16'(diff % RECUR_MOD);
			run_pos   = run_pos + 8'd1;
		end
		if (last) begin
			pending_checksums.push_back(run_newer);
			clear_terms();
		end
	endfunction

	// Sends one transaction after a random gap and predicts its effect on acceptance.
	task automatic send_item(input logic [7:0] b, input logic last, input logic none);
		int unsigned gap;
		gap = idle_len();
		if (gap != 0) begin
			msg_ch.valid     <= 1'b0;
			msg_ch.data_byte <= 8'($urandom);
			msg_ch.is_last   <= 1'($urandom);
			msg_ch.no_data   <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
		msg_ch.valid     <= 1'b1;
		msg_ch.data_byte <= b;
		msg_ch.is_last   <= last;
		msg_ch.no_data   <= none;
		@(posedge clk);
		while (!msg_ch.ready)
			@(posedge clk);
		fold_transaction(b, last, none);
		items_sent++;
	endtask

	// Sends a message of len bytes, closed by is_last or by a separate no_data transaction.
	task automatic send_message(input int unsigned len, input bit close_empty);
		for (int unsigned i = 0; i < len; i++)
			send_item(pick_byte(), (i == len - 1) && !close_empty, 1'b0);
		if (close_empty)
			send_item(8'($urandom), 1'($urandom), 1'b1);
	endtask

	// Holds the sender off until every predicted checksum has arrived.
	task automatic wait_drained();
		msg_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_checksums.size() != 0)
			@(posedge clk);
	endtask

	// Extremes and each special case of the recurrence.
	task automatic test_directed();
		// Empty messages, with is_last and the byte ignored on the second.
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hFF, 1'b1, 1'b1);
		// Single-byte messages at both extremes.
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hFF, 1'b1, 1'b0);
		// Short messages of all-ones and all-zeros.
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(8'hFF, 1'b1, 1'b0);
		repeat (2) send_item(8'h00, 1'b0, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		// Messages ended without a byte.
		send_item(8'hAA, 1'b0, 1'b0);
		send_item(8'h55, 1'b0, 1'b0);
		send_item(8'hC3, 1'b1, 1'b1);
		send_item(8'h5A, 1'b0, 1'b0);
		send_item(8'h3C, 1'b0, 1'b1);
		// Walking one through the byte.
		for (int i = 0; i < 8; i++)
			send_item(8'(1 << i), i == 7, 1'b0);
	endtask

	// Messages of at least 256 bytes, so the position wraps.
	task automatic test_long_messages();
		send_message($urandom_range(256, 270), 1'b0);
		send_message($urandom_range(256, 270), 1'b1);
	endtask

	// Back-to-back traffic with neither side idling.
	task automatic test_back_to_back();
		steady = 1'b1;
		repeat (8) send_message($urandom_range(1, 6), $urandom_range(0, 3) == 0);
		wait_drained();
		steady = 1'b0;
	endtask

	// Mostly well-formed messages of random length, with empty ones and drains mixed in.
	task automatic test_random_messages();
		int unsigned r;
		while (items_sent < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 5)
				send_item(8'($urandom), 1'($urandom), 1'b1);
			else if (r < 6)
				send_message($urandom_range(256, 264), 1'($urandom_range(0, 1)));
			else
				send_message($urandom_range(1, 16), $urandom_range(0, 9) == 0);
			if ($urandom_range(0, 29) == 0)
				wait_drained();
		end
	endtask

	// Result side: random stalls unless steady.
	initial begin
		int unsigned hold;
		hold = 0;
		sum_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold != 0) begin
				hold--;
			end else if (steady || !sum_ch.ready) begin
				sum_ch.ready <= 1'b1;
				hold = $urandom_range(0, 12);
			end else begin
				sum_ch.ready <= 1'b0;
				hold = idle_len();
			end
		end
	end

	// Compares each checksum transaction with the oldest prediction.
	always @(posedge clk) begin
		logic [15:0] want;
		if (arst_n && sum_ch.valid && sum_ch.ready) begin
			if (pending_checksums.size() == 0) begin
				$display("%0t ns: checksum %0d arrived with none expected", $time,
					sum_ch.checksum);
				errors++;
			end else begin
				want = pending_checksums.pop_front();
				if (sum_ch.checksum !== want) begin
					$display("%0t ns: checksum mismatch, expected %0d, actual %0d", $time,
						want, sum_ch.checksum);
					errors++;
				end
			end
		end
	end

	// Hard limit on the run.
	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

	// Reset, the tests in turn, then drain and report.
	initial begin
		int unsigned waited;
		errors = 0;
		items_sent = 0;
		steady = 1'b0;
		clear_terms();
		arst_n = 1'b0;
		msg_ch.valid = 1'b0;
		msg_ch.data_byte = 8'h00;
		msg_ch.is_last = 1'b0;
		msg_ch.no_data = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		wait_drained();
		test_long_messages();
		test_back_to_back();
		test_random_messages();

		msg_ch.valid <= 1'b0;
		@(posedge clk);
		steady = 1'b1;
		waited = 0;
		while (pending_checksums.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
		if (pending_checksums.size() != 0) begin
			$display("%0t ns: %0d checksums never arrived, next expected %0d", $time,
				pending_checksums.size(), pending_checksums[0]);
			errors++;
		end
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: three_term_recurrence_checksum.f
+incdir+hdl
hdl/ttrc_pkg.sv
hdl/ttrc_in_if.sv
hdl/ttrc_out_if.sv
hdl/ttrc_step.sv
hdl/three_term_recurrence_checksum.sv
hdl/ttrc_checker.sv
verif/three_term_recurrence_checksum_tb.sv
